### design/pfrp_pkg.sv
// ----------------------------------------------------------------------------
// pfrp_pkg
// Shared types and constants for the page-frame replacement table.
// ----------------------------------------------------------------------------
package pfrp_pkg;

  localparam int unsigned PAGE_W       = 20;
  localparam int unsigned FIU_W        = 5;
  localparam int unsigned CFG_W        = 5;
  localparam int unsigned CFG_IDX_W    = 1;

  localparam int unsigned FRAMES_DEF   = 16;
  localparam int unsigned AGE_BITS_DEF = 8;
  localparam int unsigned CLEAN_BIAS_DEF = 3;

  localparam logic [FIU_W-1:0]     FIU_RESET  = 5'd16;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIU    = 1'b1;
  localparam logic                 CMD_ACCESS = 1'b0;
  localparam logic                 CMD_TICK   = 1'b1;

  typedef enum logic [1:0] {
    POL_SC,
    POL_ESC,
    POL_AGE,
    POL_AGE_BIAS
  } pfrp_policy_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK,
    S_LOOK,
    S_MISS,
    S_INS,
    S_W_ORD,
    S_W_FRM,
    S_W_EVL,
    S_EVICT,
    S_REM,
    S_DONE
  } pfrp_state_e;

  typedef struct packed {
    logic              command;
    logic [PAGE_W-1:0] page_number;
    logic              is_write;
  } pfrp_in_t;

  typedef struct packed {
    logic              hit;
    logic              filled_free;
    logic              evicted;
    logic [PAGE_W-1:0] victim_page;
    logic              victim_dirty;
  } pfrp_out_t;

endpackage

### design/pfrp_ram.sv
// ----------------------------------------------------------------------------
// pfrp_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pfrp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/pfrp_ctrl.sv
// ----------------------------------------------------------------------------
// pfrp_ctrl
// Sequencer: lookup, aging sweep, list walk for victim choice, list upkeep.
// ----------------------------------------------------------------------------
module pfrp_ctrl #(
  parameter int unsigned FRAMES           = pfrp_pkg::FRAMES_DEF,
  parameter int unsigned AGE_BITS         = pfrp_pkg::AGE_BITS_DEF,
  parameter int unsigned CLEAN_BIAS_SHIFT = pfrp_pkg::CLEAN_BIAS_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        in_valid_i,
  input  pfrp_pkg::pfrp_in_t                          in_data_i,
  output logic                                        in_stall_o,
  output logic                                        out_valid_o,
  output pfrp_pkg::pfrp_out_t                         out_data_o,
  input  logic                                        out_stall_i,
  input  pfrp_pkg::pfrp_policy_e                      policy_i,
  input  logic [pfrp_pkg::FIU_W-1:0]                  fiu_i,
  output logic                                        fr_re_o,
  output logic [$clog2(FRAMES)-1:0]                   fr_raddr_o,
  input  logic [pfrp_pkg::PAGE_W+AGE_BITS+1:0]        fr_rdata_i,
  output logic                                        fr_we_o,
  output logic [$clog2(FRAMES)-1:0]                   fr_waddr_o,
  output logic [pfrp_pkg::PAGE_W+AGE_BITS+1:0]        fr_wdata_o,
  output logic                                        or_re_o,
  output logic [$clog2(FRAMES)-1:0]                   or_raddr_o,
  input  logic [$clog2(FRAMES)-1:0]                   or_rdata_i,
  output logic                                        or_we_o,
  output logic [$clog2(FRAMES)-1:0]                   or_waddr_o,
  output logic [$clog2(FRAMES)-1:0]                   or_wdata_o
);

  import pfrp_pkg::*;

  localparam int unsigned IW = $clog2(FRAMES);
  localparam int unsigned CW = $clog2(FRAMES + 1);
  localparam int unsigned FW = PAGE_W + AGE_BITS + 2;
  localparam int unsigned LW = (CW > FIU_W) ? CW : FIU_W;
  localparam logic [AGE_BITS-1:0] AGE_TOP = {1'b1, {(AGE_BITS-1){1'b0}}};
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  pfrp_state_e state_q, state_d;
  logic [CW-1:0]       n_q, n_d, k_q, k_d, rem_q, rem_d;
  logic [IW-1:0]       head_q, head_d, s_q, s_d, ra_q, ra_d, frm_q, frm_d;
  logic [PAGE_W-1:0]   page_q, page_d;
  logic                wr_q, wr_d, fv_q, fv_d;
  logic [1:0]          phase_q, phase_d;
  logic [IW-1:0]       best_frm_q, best_frm_d, best_slot_q, best_slot_d, best_k_q, best_k_d;
  logic [PAGE_W-1:0]   best_page_q, best_page_d;
  logic [AGE_BITS-1:0] best_age_q, best_age_d;
  logic                best_dirty_q, best_dirty_d, d0_q, d0_d, same_q, same_d;
  pfrp_out_t           res_q, res_d, out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic [PAGE_W-1:0]   rd_page;
  logic                rd_ref, rd_dirty;
  logic [AGE_BITS-1:0] rd_age;
  logic [FW-1:0]       new_rec;
  logic                accept, take_out, room, k_last, look_hit, scan_end;
  logic [LW-1:0]       lim, fiu_ext;
  logic [CW-1:0]       s_p1, bs_p1;
  logic [IW-1:0]       s_inc, bs_inc;
  logic                clr_ref, upd_best, go_evict, same_nx, d0_nx, bdirty_nx;
  logic [1:0]          phase_nx;

  assign rd_page  = fr_rdata_i[FW-1 -: PAGE_W];
  assign rd_ref   = fr_rdata_i[AGE_BITS+1];
  assign rd_dirty = fr_rdata_i[AGE_BITS];
  assign rd_age   = fr_rdata_i[AGE_BITS-1:0];
  assign new_rec  = {page_q, 1'b1, wr_q, AGE_TOP};

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign take_out = !out_valid_q || !out_stall_i;
  assign fiu_ext  = LW'(fiu_i);
  assign lim      = (fiu_i == '0) ? LW'(1) :
                    ((fiu_ext > LW'(FRAMES)) ? LW'(FRAMES) : fiu_ext);
  assign room     = LW'(n_q) < lim;
  assign k_last   = (k_q == n_q - CW'(1));
  assign look_hit = fv_q && (rd_page == page_q);
  assign scan_end = (k_q == n_q) && !fv_q;
  assign s_p1     = CW'(s_q) + CW'(1);
  assign s_inc    = (s_p1 == n_q) ? '0 : s_p1[IW-1:0];
  assign bs_p1    = CW'(best_slot_q) + CW'(1);
  assign bs_inc   = (bs_p1 == n_q) ? '0 : bs_p1[IW-1:0];

  // victim choice for one visited list position
  always_comb begin
    clr_ref   = 1'b0;
    upd_best  = 1'b0;
    go_evict  = 1'b0;
    phase_nx  = phase_q;
    same_nx   = same_q;
    d0_nx     = d0_q;
    bdirty_nx = best_dirty_q;
    case (policy_i)
      POL_SC: begin
        if (rd_ref) begin
          clr_ref = 1'b1;
        end else begin
          upd_best = 1'b1;
          go_evict = 1'b1;
        end
      end
      POL_ESC: begin
        case (phase_q)
          PH_FIRST: begin
            if (!rd_ref && !rd_dirty) begin
              upd_best = 1'b1;
              go_evict = 1'b1;
            end else if (k_last) begin
              phase_nx = PH_SECOND;
            end
          end
          PH_SECOND: begin
            clr_ref = rd_ref;
            if (!rd_ref) begin
              upd_best = 1'b1;
              go_evict = 1'b1;
            end else if (k_last) begin
              phase_nx = PH_THIRD;
            end
          end
          default: begin
            if (k_q == '0 || !rd_dirty) begin
              upd_best = 1'b1;
            end
            if (!rd_dirty || k_last) begin
              go_evict = 1'b1;
            end
          end
        endcase
      end
      default: begin
        if (phase_q == PH_FIRST) begin
          if (k_q == '0) begin
            upd_best = 1'b1;
            d0_nx    = rd_dirty;
            same_nx  = 1'b1;
          end else begin
            upd_best = rd_age < best_age_q;
            if (rd_dirty != d0_q) begin
              same_nx = 1'b0;
            end
          end
          bdirty_nx = upd_best ? rd_dirty : best_dirty_q;
          if (k_last) begin
            if (policy_i == POL_AGE_BIAS && !same_nx && bdirty_nx) begin
              phase_nx = PH_SECOND;
            end else begin
              go_evict = 1'b1;
            end
          end
        end else begin
          if (!rd_dirty) begin
            if (best_dirty_q) begin
              upd_best = (rd_age >> CLEAN_BIAS_SHIFT) <= best_age_q;
            end else begin
              upd_best = rd_age < best_age_q;
            end
          end
          go_evict = k_last;
        end
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_data_i.command == CMD_TICK) begin
            state_d = (n_q == '0) ? S_DONE : S_TICK;
          end else begin
            state_d = (n_q == '0) ? S_MISS : S_LOOK;
          end
        end
      end
      S_TICK:  if (scan_end) state_d = S_DONE;
      S_LOOK: begin
        if (look_hit) begin
          state_d = S_DONE;
        end else if (scan_end) begin
          state_d = S_MISS;
        end
      end
      S_MISS: begin
        if (room) begin
          state_d = (head_q == '0) ? S_DONE : S_INS;
        end else begin
          state_d = S_W_ORD;
        end
      end
      S_INS:   if (rem_q == '0 && !fv_q) state_d = S_DONE;
      S_W_ORD: state_d = S_W_FRM;
      S_W_FRM: state_d = S_W_EVL;
      S_W_EVL: state_d = go_evict ? S_EVICT : S_W_ORD;
      S_EVICT: state_d = (policy_i == POL_SC || policy_i == POL_ESC) ? S_DONE : S_REM;
      S_REM:   if (rem_q == '0 && !fv_q) state_d = S_DONE;
      S_DONE:  if (take_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    n_d = n_q; k_d = k_q; rem_d = rem_q; head_d = head_q; s_d = s_q; ra_d = ra_q;
    frm_d = frm_q; page_d = page_q; wr_d = wr_q; fv_d = fv_q; phase_d = phase_q;
    best_frm_d = best_frm_q; best_slot_d = best_slot_q; best_k_d = best_k_q;
    best_page_d = best_page_q; best_age_d = best_age_q; best_dirty_d = best_dirty_q;
    d0_d = d0_q; same_d = same_q; res_d = res_q; out_d = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    fr_re_o = 1'b0; fr_raddr_o = k_q[IW-1:0];
    fr_we_o = 1'b0; fr_waddr_o = ra_q; fr_wdata_o = fr_rdata_i;
    or_re_o = 1'b0; or_raddr_o = s_q;
    or_we_o = 1'b0; or_waddr_o = ra_q; or_wdata_o = or_rdata_i;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          page_d = in_data_i.page_number;
          wr_d   = in_data_i.is_write;
          k_d    = '0;
          fv_d   = 1'b0;
          res_d  = '0;
        end
      end
      S_TICK, S_LOOK: begin
        fv_d = k_q < n_q;
        if (k_q < n_q) begin
          fr_re_o = 1'b1;
          ra_d    = k_q[IW-1:0];
          k_d     = k_q + CW'(1);
        end
        if (state_q == S_TICK) begin
          fr_we_o    = fv_q;
          fr_wdata_o = {rd_page, rd_ref, rd_dirty, rd_age >> 1};
        end else if (look_hit) begin
          fr_we_o    = 1'b1;
          fr_wdata_o = {rd_page, 1'b1, rd_dirty | wr_q, rd_age | AGE_TOP};
          res_d.hit  = 1'b1;
        end
      end
      S_MISS: begin
        if (room) begin
          fr_we_o           = 1'b1;
          fr_waddr_o        = n_q[IW-1:0];
          fr_wdata_o        = new_rec;
          res_d.filled_free = 1'b1;
          n_d               = n_q + CW'(1);
          frm_d             = n_q[IW-1:0];
          or_waddr_o        = n_q[IW-1:0];
          or_wdata_o        = n_q[IW-1:0];
          or_we_o           = (head_q == '0);
          rem_d             = n_q - CW'(head_q);
          s_d               = IW'(n_q - CW'(1));
          fv_d              = 1'b0;
        end else begin
          s_d     = head_q;
          k_d     = '0;
          phase_d = PH_FIRST;
        end
      end
      S_INS: begin
        fv_d = rem_q != '0;
        if (rem_q != '0) begin
          or_re_o = 1'b1;
          ra_d    = s_q;
          s_d     = s_q - IW'(1);
          rem_d   = rem_q - CW'(1);
        end
        if (fv_q) begin
          or_we_o    = 1'b1;
          or_waddr_o = ra_q + IW'(1);
        end else if (rem_q == '0) begin
          or_we_o    = 1'b1;
          or_waddr_o = head_q;
          or_wdata_o = frm_q;
          head_d     = head_q + IW'(1);
        end
      end
      S_W_ORD: or_re_o = 1'b1;
      S_W_FRM: begin
        frm_d      = or_rdata_i;
        fr_re_o    = 1'b1;
        fr_raddr_o = or_rdata_i;
      end
      S_W_EVL: begin
        fr_we_o    = clr_ref;
        fr_waddr_o = frm_q;
        fr_wdata_o = {rd_page, 1'b0, rd_dirty, rd_age};
        phase_d    = phase_nx;
        same_d     = same_nx;
        d0_d       = d0_nx;
        if (upd_best) begin
          best_frm_d   = frm_q;
          best_slot_d  = s_q;
          best_k_d     = k_q[IW-1:0];
          best_page_d  = rd_page;
          best_age_d   = rd_age;
          best_dirty_d = rd_dirty;
        end
        if (!go_evict) begin
          s_d = s_inc;
          k_d = k_last ? '0 : k_q + CW'(1);
        end
      end
      S_EVICT: begin
        fr_we_o            = 1'b1;
        fr_waddr_o         = best_frm_q;
        fr_wdata_o         = new_rec;
        res_d.evicted      = 1'b1;
        res_d.victim_page  = best_page_q;
        res_d.victim_dirty = best_dirty_q;
        head_d = (policy_i == POL_SC || policy_i == POL_ESC) ? bs_inc : head_q;
        s_d    = best_slot_q;
        rem_d  = n_q - CW'(best_k_q) - CW'(1);
        fv_d   = 1'b0;
      end
      S_REM: begin
        fv_d = rem_q != '0;
        if (rem_q != '0) begin
          or_re_o    = 1'b1;
          or_raddr_o = s_inc;
          ra_d       = s_q;
          s_d        = s_inc;
          rem_d      = rem_q - CW'(1);
        end
        if (fv_q) begin
          or_we_o = 1'b1;
        end else if (rem_q == '0) begin
          or_we_o    = 1'b1;
          or_waddr_o = s_q;
          or_wdata_o = best_frm_q;
        end
      end
      S_DONE: begin
        if (take_out) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= '0;
      head_q      <= '0;
      fv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      head_q      <= head_d;
      fv_q        <= fv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d; rem_q <= rem_d; s_q <= s_d; ra_q <= ra_d; frm_q <= frm_d;
    page_q <= page_d; wr_q <= wr_d; phase_q <= phase_d;
    best_frm_q <= best_frm_d; best_slot_q <= best_slot_d; best_k_q <= best_k_d;
    best_page_q <= best_page_d; best_age_q <= best_age_d; best_dirty_q <= best_dirty_d;
    d0_q <= d0_d; same_q <= same_d; res_q <= res_d; out_q <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### design/page_frame_replacement_policy.sv
// ----------------------------------------------------------------------------
// page_frame_replacement_policy
// Page-frame table with second-chance and aging replacement.
//
// Input channel (in_valid_i / in_stall_o) carries a page access or an aging
// tick; one transaction is taken when valid is high and stall is low. Each
// input transaction yields exactly one output transaction (out_valid_o /
// out_stall_i), in order. One item is processed at a time; stall stays high
// from acceptance until the result is loaded into the output register.
// With n filled frames an aging tick sweeps all n frames, a hit is found by
// a scan of up to n frames, and a fill of a free frame may be followed by
// list shifting. An eviction walks the list, reading each visited frame's
// list entry, then its frame record, then evaluating it (one pass for aging,
// up to two for enhanced aging, up to n+1 visits for second chance, up to 3n
// for enhanced second chance), followed for aging by list shifting. The walk
// steps follow from the registered read ports of the list and frame RAMs.
// The output register lets the next item start while a result waits under
// stall. Reset empties the table, restores policy 0 and a limit of 16 frames
// capped at FRAMES; no clearing pass is needed. Configuration writes take
// effect at once; the user must make them while idle, which is not enforced.
// ----------------------------------------------------------------------------
module page_frame_replacement_policy #(
  parameter int unsigned FRAMES           = pfrp_pkg::FRAMES_DEF,
  parameter int unsigned AGE_BITS         = pfrp_pkg::AGE_BITS_DEF,
  parameter int unsigned CLEAN_BIAS_SHIFT = pfrp_pkg::CLEAN_BIAS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  pfrp_pkg::pfrp_in_t               in_data_i,
  output logic                             in_stall_o,
  output logic                             out_valid_o,
  output pfrp_pkg::pfrp_out_t              out_data_o,
  input  logic                             out_stall_i,
  input  logic                             cfg_we_i,
  input  logic [pfrp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [pfrp_pkg::CFG_W-1:0]       cfg_wdata_i
);

  import pfrp_pkg::*;

  localparam int unsigned IW = $clog2(FRAMES);
  localparam int unsigned FW = PAGE_W + AGE_BITS + 2;

  pfrp_policy_e     policy_q;
  logic [FIU_W-1:0] fiu_q;

  logic          fr_re, fr_we, or_re, or_we;
  logic [IW-1:0] fr_raddr, fr_waddr, or_raddr, or_waddr, or_rdata, or_wdata;
  logic [FW-1:0] fr_rdata, fr_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POL_SC;
      fiu_q    <= FIU_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POLICY: policy_q <= pfrp_policy_e'(cfg_wdata_i[1:0]);
        CFG_FIU:    fiu_q    <= cfg_wdata_i[FIU_W-1:0];
        default: ;
      endcase
    end
  end

  pfrp_ram #(.WIDTH(FW), .DEPTH(FRAMES)) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (fr_we),
    .waddr_i (fr_waddr),
    .wdata_i (fr_wdata),
    .re_i    (fr_re),
    .raddr_i (fr_raddr),
    .rdata_o (fr_rdata)
  );

  pfrp_ram #(.WIDTH(IW), .DEPTH(FRAMES)) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (or_we),
    .waddr_i (or_waddr),
    .wdata_i (or_wdata),
    .re_i    (or_re),
    .raddr_i (or_raddr),
    .rdata_o (or_rdata)
  );

  pfrp_ctrl #(
    .FRAMES           (FRAMES),
    .AGE_BITS         (AGE_BITS),
    .CLEAN_BIAS_SHIFT (CLEAN_BIAS_SHIFT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i),
    .policy_i    (policy_q),
    .fiu_i       (fiu_q),
    .fr_re_o     (fr_re),
    .fr_raddr_o  (fr_raddr),
    .fr_rdata_i  (fr_rdata),
    .fr_we_o     (fr_we),
    .fr_waddr_o  (fr_waddr),
    .fr_wdata_o  (fr_wdata),
    .or_re_o     (or_re),
    .or_raddr_o  (or_raddr),
    .or_rdata_i  (or_rdata),
    .or_we_o     (or_we),
    .or_waddr_o  (or_waddr),
    .or_wdata_o  (or_wdata)
  );

endmodule

### design/pfrp_checker.sv
// ----------------------------------------------------------------------------
// pfrp_checker
// Port-level checks on the result channel of the page-frame table.
// ----------------------------------------------------------------------------
module pfrp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input pfrp_pkg::pfrp_out_t out_data_o
);

  import pfrp_pkg::*;

  hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  one_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({out_data_o.hit, out_data_o.filled_free, out_data_o.evicted}))
    else $error("more than one outcome flagged");

  victim_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.evicted |->
      out_data_o.victim_page == '0 && !out_data_o.victim_dirty)
    else $error("victim fields set without eviction");

endmodule

bind page_frame_replacement_policy pfrp_checker u_pfrp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
